// ===== hw/rtl/dual_lane_frame_crc_checker_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual-lane frame CRC checker
// Concurrent checks clocked on the rising edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef DUAL_LANE_FRAME_CRC_CHECKER_ASSERT_SVH
`define DUAL_LANE_FRAME_CRC_CHECKER_ASSERT_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge out of reset.
`define DLFCC_ASSERT(label, prop, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dlfcc assertion failed");

// Implication: when ante holds, cons must hold at the same edge.
`define DLFCC_ASSERT_IMPL(label, ante, cons, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlfcc implication failed");

// Implication: when ante holds, cons must hold at the next edge.
`define DLFCC_ASSERT_NEXT(label, ante, cons, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlfcc next-cycle check failed");

`else

`define DLFCC_ASSERT(label, prop, clk, rst_n)
`define DLFCC_ASSERT_IMPL(label, ante, cons, clk, rst_n)
`define DLFCC_ASSERT_NEXT(label, ante, cons, clk, rst_n)

`endif

`endif

// ===== hw/rtl/dlfcc_pkg.sv =====
// ----------------------------------------------------------------------------
// dlfcc_pkg
// Types, codes and helpers shared by the dual-lane frame CRC checker.
// ----------------------------------------------------------------------------
package dlfcc_pkg;

  localparam int unsigned DLFCC_BLOCKS_PER_FRAME    = 16;
  localparam int unsigned DLFCC_DATA_WORDS_PER_GAIN = 2;

  localparam logic [15:0] LANE_POLY = 16'h8005;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_BLOCKS = 2'd1,
    PH_GLOBAL_CRC = 2'd2,
    PH_END = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_HEADER1 = 3'd1,
    KIND_DATA1 = 3'd2,
    KIND_HEADER2 = 3'd3,
    KIND_DATA2 = 3'd4,
    KIND_BLOCK_CRC = 3'd5,
    KIND_GLOBAL_CRC = 3'd6,
    KIND_END = 3'd7
  } kind_e;

  typedef struct packed {
    logic [31:0] link_word;
    logic        link_error;
  } in_t;

  typedef struct packed {
    logic [2:0]  word_kind;
    logic [3:0]  block_number;
    logic [15:0] lane_even_crc;
    logic [15:0] lane_odd_crc;
    logic [15:0] received_even_crc;
    logic [15:0] received_odd_crc;
    logic        crc_match;
    logic        frame_done;
    logic        frame_aborted;
  } out_t;

  // Control for one lane CRC unit.
  typedef struct packed {
    logic update;     // commit a new CRC value
    logic clear;      // start from zero (first header of a block)
    logic zero_fill;  // shift in 16 zeros instead of the lane bits
  } lane_ctrl_t;

  // Pick one lane out of an interleaved word: bit 2k+odd goes to bit k.
  function automatic logic [15:0] lane_bits(logic [31:0] w, logic odd);
    logic [15:0] r;
    for (int k = 0; k < 16; k++) begin
      r[k] = odd ? w[2*k+1] : w[2*k];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/dual_lane_frame_crc_checker.sv =====
// ----------------------------------------------------------------------------
// dual_lane_frame_crc_checker
// Frame walker and per-block CRC check for two bit-interleaved readout lanes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one 32-bit link
//   word plus its read-error flag per transaction. Output channel
//   (out_valid_o/out_ready_i/out_data_o) returns exactly one result per input
//   transaction: word kind, block number, both running lane CRCs and, on the
//   block CRC word, the received lane values and the match flag.
//   The word lands in the input register, the frame walker and both
//   unrolled lane CRC updates run combinationally between the two
//   registers, and the result is written to the output register.
//   Throughput is 1 transaction per cycle while out_ready_i stays high,
//   with each lane CRC's 16-bit XOR update unrolled; while a result waits
//   in the output register, only an empty input register takes a word.
//   When the receiver stalls, the output register holds, then the input
//   register fills, and in_ready_o drops until out_ready_i returns.
//   Reset clears both registers' valid flags, the lane CRCs, the block and
//   slot counters, and puts the walker back to waiting for a start word.
//   A word flagged with a read error aborts the frame; the next word is
//   taken as a start word.
// ----------------------------------------------------------------------------
`include "dual_lane_frame_crc_checker_assert.svh"

module dual_lane_frame_crc_checker #(
  parameter int unsigned BLOCKS_PER_FRAME    = dlfcc_pkg::DLFCC_BLOCKS_PER_FRAME,
  parameter int unsigned DATA_WORDS_PER_GAIN = dlfcc_pkg::DLFCC_DATA_WORDS_PER_GAIN
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dlfcc_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output dlfcc_pkg::out_t out_data_o
);
  import dlfcc_pkg::*;

  localparam logic [2:0] SLOT_LAST_DATA1 = 3'(DATA_WORDS_PER_GAIN);
  localparam logic [2:0] SLOT_HEADER2    = 3'(DATA_WORDS_PER_GAIN + 1);
  localparam logic [2:0] SLOT_LAST_DATA2 = 3'(2 * DATA_WORDS_PER_GAIN + 1);
  localparam logic [2:0] SLOT_CRC        = 3'(2 * DATA_WORDS_PER_GAIN + 2);
  localparam logic [4:0] BLOCKS_LIMIT    = 5'(BLOCKS_PER_FRAME);

  // Input register
  logic   in_valid_q;
  in_t    in_q;
  // Output register
  logic   out_valid_q;
  out_t   out_q;
  out_t   res;
  logic   advance;

  // Frame walker state
  phase_e      phase_q, phase_d;
  logic [3:0]  blk_q, blk_d;
  logic [2:0]  slot_q, slot_d;
  kind_e       kind;
  logic [4:0]  blk_inc;

  // Lanes
  lane_ctrl_t  lane_ctrl;
  logic [15:0] rx_even, rx_odd;
  logic [15:0] even_crc_d, odd_crc_d;
  logic        even_match, odd_match;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Word kind from phase and slot
  always_comb begin
    case (phase_q)
      PH_START:      kind = KIND_START;
      PH_GLOBAL_CRC: kind = KIND_GLOBAL_CRC;
      PH_END:        kind = KIND_END;
      PH_BLOCKS: begin
        if (slot_q == 3'd0) begin
          kind = KIND_HEADER1;
        end else if (slot_q <= SLOT_LAST_DATA1) begin
          kind = KIND_DATA1;
        end else if (slot_q == SLOT_HEADER2) begin
          kind = KIND_HEADER2;
        end else if (slot_q <= SLOT_LAST_DATA2) begin
          kind = KIND_DATA2;
        end else begin
          kind = KIND_BLOCK_CRC;
        end
      end
      default:       kind = KIND_START;
    endcase
  end

  assign rx_even = lane_bits(in_q.link_word, 1'b0);
  assign rx_odd  = lane_bits(in_q.link_word, 1'b1);
  assign blk_inc = {1'b0, blk_q} + 5'd1;

  // Next state and lane control
  always_comb begin
    phase_d   = phase_q;
    blk_d     = blk_q;
    slot_d    = slot_q;
    lane_ctrl = '0;
    if (in_q.link_error) begin
      // drop the word and restart at the start word
      phase_d = PH_START;
      blk_d   = 4'd0;
      slot_d  = 3'd0;
    end else begin
      case (phase_q)
        PH_START: begin
          phase_d = PH_BLOCKS;
          blk_d   = 4'd0;
          slot_d  = 3'd0;
        end
        PH_BLOCKS: begin
          lane_ctrl.update = 1'b1;
          if (kind == KIND_BLOCK_CRC) begin
            lane_ctrl.zero_fill = 1'b1;
            slot_d = 3'd0;
            if (blk_inc >= BLOCKS_LIMIT) begin
              blk_d   = 4'd0;
              phase_d = PH_GLOBAL_CRC;
            end else begin
              blk_d = blk_inc[3:0];
            end
          end else begin
            lane_ctrl.clear = (kind == KIND_HEADER1);
            slot_d = slot_q + 3'd1;
          end
        end
        PH_GLOBAL_CRC: phase_d = PH_END;
        PH_END:        phase_d = PH_START;
        default:       phase_d = PH_START;
      endcase
    end
    lane_ctrl.update = lane_ctrl.update && advance;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      blk_q   <= 4'd0;
      slot_q  <= 3'd0;
    end else if (advance) begin
      phase_q <= phase_d;
      blk_q   <= blk_d;
      slot_q  <= slot_d;
    end
  end

  dlfcc_lane u_lane_even (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (lane_ctrl),
    .lane_bits_i (rx_even),
    .crc_d_o     (even_crc_d),
    .match_o     (even_match)
  );

  dlfcc_lane u_lane_odd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (lane_ctrl),
    .lane_bits_i (rx_odd),
    .crc_d_o     (odd_crc_d),
    .match_o     (odd_match)
  );

  // Result assembly
  always_comb begin
    res = '0;
    res.word_kind     = kind;
    res.block_number  = (phase_q == PH_BLOCKS) ? blk_q : 4'd0;
    res.lane_even_crc = even_crc_d;
    res.lane_odd_crc  = odd_crc_d;
    if (in_q.link_error) begin
      res.frame_aborted = 1'b1;
    end else if (phase_q == PH_BLOCKS && kind == KIND_BLOCK_CRC) begin
      res.received_even_crc = rx_even;
      res.received_odd_crc  = rx_odd;
      res.crc_match         = even_match && odd_match;
    end else if (phase_q == PH_END) begin
      res.frame_done = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DLFCC_ASSERT_IMPL(a_match_on_crc_word, out_valid_o && out_data_o.crc_match, out_data_o.word_kind == KIND_BLOCK_CRC, clk_i, rst_ni)
  `DLFCC_ASSERT_IMPL(a_done_abort_exclusive, out_valid_o, !(out_data_o.frame_done && out_data_o.frame_aborted), clk_i, rst_ni)
  `DLFCC_ASSERT_IMPL(a_counters_idle, phase_q != PH_BLOCKS, blk_q == 4'd0 && slot_q == 3'd0, clk_i, rst_ni)
  `DLFCC_ASSERT(a_slot_in_range, slot_q <= SLOT_CRC, clk_i, rst_ni)
  `DLFCC_ASSERT_NEXT(a_abort_restarts, advance && in_q.link_error, phase_q == PH_START, clk_i, rst_ni)

endmodule

// ===== hw/rtl/dlfcc_lane.sv =====
// ----------------------------------------------------------------------------
// dlfcc_lane
// One serial lane: CRC-16 register (poly 0x8005, shift-in form) with a
// 16-bit-per-cycle unrolled update (while update is set) and a compare against received bits.
// ----------------------------------------------------------------------------
module dlfcc_lane (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dlfcc_pkg::lane_ctrl_t  ctrl_i,
  input  logic [15:0]            lane_bits_i,
  output logic [15:0]            crc_d_o,
  output logic                   match_o
);
  import dlfcc_pkg::*;

  logic [15:0] crc_q;
  logic [15:0] crc_base;
  logic [15:0] feed_bits;

  // Sixteen shift-in steps, lowest lane bit first; pure XOR after unrolling.
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [15:0] bits);
    logic [15:0] c;
    logic        msb;
    c = crc;
    for (int k = 0; k < 16; k++) begin
      msb = c[15];
      c   = {c[14:0], bits[k]};
      if (msb) begin
        c = c ^ LANE_POLY;
      end
    end
    return c;
  endfunction

  always_comb begin
    crc_base  = ctrl_i.clear ? 16'h0000 : crc_q;
    feed_bits = ctrl_i.zero_fill ? 16'h0000 : lane_bits_i;
    crc_d_o   = ctrl_i.update ? crc_feed(crc_base, feed_bits) : crc_q;
  end

  assign match_o = (crc_d_o == lane_bits_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= 16'h0000;
    end else if (ctrl_i.update) begin
      crc_q <= crc_d_o;
    end
  end

endmodule
